// ===== sv/cross_median_filter_2d_core_macros.svh =====
// Assertion macros used by the checker file.
`ifndef CROSS_MEDIAN_FILTER_2D_CORE_MACROS_SVH
`define CROSS_MEDIAN_FILTER_2D_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CMF2D_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CMF2D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// What must hold in the cycle after reset.
`define CMF2D_ASSERT_RST(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

// ===== sv/cmf2d_pkg.sv =====
package cmf2d_pkg;

  localparam int DEF_MAX_WIDTH   = 2048;
  localparam int DEF_SAMPLE_BITS = 16;

  localparam int WIDTH_REG_BITS  = 12;
  localparam int HEIGHT_BITS     = 16;
  localparam logic [WIDTH_REG_BITS-1:0] WIDTH_RESET  = 12'd512;
  localparam logic [HEIGHT_BITS-1:0]    HEIGHT_RESET = 16'd512;
  localparam int MIN_DIM         = 3;

  // Register map: one 32-bit register every four bytes.
  localparam int PADDR_BITS  = 3;
  localparam int REG_SEL_BIT = 2;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic FUNC_DRAIN = 1'b1;

  typedef struct packed {
    logic border;
    logic last;
  } cmf2d_tag_t;

endpackage

// ===== sv/cross_median_filter_2d_core.sv =====
// Five-point cross median filter, one pixel transfer per cycle while the output is not stalled.
// The result for raster position p leaves after the input transfer of position p + W + 1
// (W = image width), via the read and median stages; W + 1 drain transfers flush a frame.
// The line store is one RAM read and written once per pixel; a read-modify-write of the
// same column in back-to-back cycles is covered by forwarding.
// Reset loads 512 x 512, clears counters, window and pipeline; the line RAM is not cleared.
module cross_median_filter_2d_core import cmf2d_pkg::*; #(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [PADDR_BITS-1:0]                paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // s_tdata: pixel_in
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
  // s_tuser: func
  input  logic [0:0]                           s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // m_tdata: pixel_out
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]     m_tdata,
  output logic                                 m_tlast
);

  localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int RW = HEIGHT_BITS + 1;
  localparam int SB = SAMPLE_BITS;

  // Configuration registers.
  logic [WIDTH_REG_BITS-1:0] width_reg;
  logic [HEIGHT_BITS-1:0]    height_reg;
  logic                      cfg_wr;
  logic [WW-1:0]             w_eff;
  logic [HEIGHT_BITS-1:0]    h_eff;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      case (paddr[REG_SEL_BIT])
        REG_WIDTH:  width_reg  <= pwdata[WIDTH_REG_BITS-1:0];
        REG_HEIGHT: height_reg <= pwdata[HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[REG_SEL_BIT])
      REG_WIDTH:  prdata = 32'(width_reg);
      REG_HEIGHT: prdata = 32'(height_reg);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    if (32'(width_reg) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else if (32'(width_reg) < 32'(MIN_DIM)) begin
      w_eff = WW'(MIN_DIM);
    end else begin
      w_eff = WW'(width_reg);
    end
    if (32'(height_reg) < 32'(MIN_DIM)) begin
      h_eff = HEIGHT_BITS'(MIN_DIM);
    end else begin
      h_eff = height_reg;
    end
  end

  // Position counters and per-item decisions at the accepting transfer.
  logic [CW-1:0] col, col_next, c_eff;
  logic [RW-1:0] row, row_next;
  logic [WW-1:0] c_plus;
  logic          all_in, early_drain, issue, has_out, last;
  cmf2d_tag_t    tag;
  logic [SB-1:0] x_in;

  always_comb begin
    c_eff       = (WW'(col) >= w_eff) ? '0 : col;
    c_plus      = WW'(c_eff) + WW'(1);
    all_in      = row >= RW'(h_eff);
    early_drain = !all_in && (s_tuser[0] == FUNC_DRAIN);
    issue       = s_tvalid && s_tready && !early_drain;
    has_out     = (row >= RW'(2)) || ((row == RW'(1)) && (c_eff != '0));
    last        = (c_eff == '0) && (row == RW'(h_eff) + RW'(1));
    tag.border  = (c_eff == '0) || (c_eff == CW'(1)) || (row == RW'(1)) ||
                  (row == RW'(h_eff));
    tag.last    = last;
    x_in        = all_in ? '0 : s_tdata[SB-1:0];
    if (last) begin
      col_next = '0;
      row_next = '0;
    end else if (c_plus == w_eff) begin
      col_next = '0;
      row_next = row + RW'(1);
    end else begin
      col_next = CW'(c_plus);
      row_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      col <= '0;
      row <= '0;
    end else if (issue) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // Read stage: line RAM data arrives here and is written back on the way out.
  logic          a_valid, a_out, a_fire, med_ready;
  logic [CW-1:0] a_col;
  logic [SB-1:0] a_x;
  cmf2d_tag_t    a_tag;
  logic          fwd_hit;
  logic [SB-1:0] fwd_up, fwd_mid, m_eff, u_eff;
  logic [2*SB-1:0] ram_rdata;

  assign a_fire   = a_valid && (!a_out || med_ready);
  assign s_tready = !a_valid || a_fire;

  // Each entry holds the upper row in the high half and the middle row in the low half.
  cmf2d_ram #(
    .WIDTH (2 * SB),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (a_fire),
    .waddr (a_col),
    .wdata ({m_eff, a_x}),
    .re    (issue),
    .raddr (c_eff),
    .rdata (ram_rdata)
  );

  assign m_eff = fwd_hit ? fwd_mid : ram_rdata[SB-1:0];
  assign u_eff = fwd_hit ? fwd_up : ram_rdata[2*SB-1:SB];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      fwd_hit <= 1'b0;
    end else if (issue) begin
      a_valid <= 1'b1;
      fwd_hit <= a_fire && (a_col == c_eff);
    end else if (a_fire) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      a_col   <= c_eff;
      a_x     <= x_in;
      a_out   <= has_out;
      a_tag   <= tag;
      fwd_up  <= m_eff;
      fwd_mid <= a_x;
    end
  end

  // Cross window: up, left, centre and down; the right sample is the fresh RAM read.
  logic [SB-1:0] win_up, win_left, win_ctr, win_down;

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      win_up   <= '0;
      win_left <= '0;
      win_ctr  <= '0;
      win_down <= '0;
    end else if (a_fire) begin
      if (a_tag.last && a_out) begin
        win_up   <= '0;
        win_left <= '0;
        win_ctr  <= '0;
        win_down <= '0;
      end else begin
        win_up   <= u_eff;
        win_left <= win_ctr;
        win_ctr  <= m_eff;
        win_down <= a_x;
      end
    end
  end

  logic [SB-1:0] med_pixel;

  cmf2d_median #(
    .SAMPLE_BITS (SB)
  ) u_median (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_valid && a_out),
    .in_ready  (med_ready),
    .in_up     ($signed(win_up)),
    .in_left   ($signed(win_left)),
    .in_ctr    ($signed(win_ctr)),
    .in_right  ($signed(m_eff)),
    .in_down   ($signed(win_down)),
    .in_tag    (a_tag),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pixel (med_pixel),
    .out_last  (m_tlast)
  );

  assign m_tdata = DW'(med_pixel);

endmodule

// ===== sv/cmf2d_ram.sv =====
module cmf2d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read of the entry written in the same cycle returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/cmf2d_median.sv =====
module cmf2d_median import cmf2d_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_up,
  input  logic signed [SAMPLE_BITS-1:0] in_left,
  input  logic signed [SAMPLE_BITS-1:0] in_ctr,
  input  logic signed [SAMPLE_BITS-1:0] in_right,
  input  logic signed [SAMPLE_BITS-1:0] in_down,
  input  cmf2d_tag_t                    in_tag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [SAMPLE_BITS-1:0]        out_pixel,
  output logic                          out_last
);

  function automatic logic signed [SAMPLE_BITS-1:0] smin(
    input logic signed [SAMPLE_BITS-1:0] x,
    input logic signed [SAMPLE_BITS-1:0] y
  );
    return (x > y) ? y : x;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] smax(
    input logic signed [SAMPLE_BITS-1:0] x,
    input logic signed [SAMPLE_BITS-1:0] y
  );
    return (x > y) ? x : y;
  endfunction

  logic b_valid, c_valid, b_ready, c_ready;
  logic signed [SAMPLE_BITS-1:0] b_a, b_b, b_c, b_d, b_e, b_ctr;
  cmf2d_tag_t b_tag;
  logic signed [SAMPLE_BITS-1:0] a1, b1, d1, e1, a2, c2, b3, c3;
  logic signed [SAMPLE_BITS-1:0] d4, c5, d5, b6, e6, c7, d8, c9;
  logic [SAMPLE_BITS-1:0] c_pixel;
  logic c_last;

  assign c_ready  = !c_valid || out_ready;
  assign b_ready  = !b_valid || c_ready;
  assign in_ready = b_ready;

  // First half of the five-input network: the first four exchanges.
  always_comb begin
    a1 = smin(in_up, in_left);
    b1 = smax(in_up, in_left);
    d1 = smin(in_right, in_down);
    e1 = smax(in_right, in_down);
    a2 = smin(a1, in_ctr);
    c2 = smax(a1, in_ctr);
    b3 = smin(b1, c2);
    c3 = smax(b1, c2);
  end

  // Second half, keeping only the lanes that reach the middle output.
  always_comb begin
    d4 = smax(b_a, b_d);
    c5 = smin(b_c, d4);
    d5 = smax(b_c, d4);
    b6 = smin(b_b, b_e);
    e6 = smax(b_b, b_e);
    c7 = smax(b6, c5);
    d8 = smin(d5, e6);
    c9 = smin(c7, d8);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (b_ready) begin
        b_valid <= in_valid;
      end
      if (c_ready) begin
        c_valid <= b_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready && in_valid) begin
      b_a   <= a2;
      b_b   <= b3;
      b_c   <= c3;
      b_d   <= d1;
      b_e   <= e1;
      b_ctr <= in_ctr;
      b_tag <= in_tag;
    end
    if (c_ready && b_valid) begin
      c_pixel <= b_tag.border ? b_ctr : c9;
      c_last  <= b_tag.last;
    end
  end

  assign out_valid = c_valid;
  assign out_pixel = c_pixel;
  assign out_last  = c_last;

endmodule

// ===== sv/cmf2d_checker.sv =====
`include "cross_median_filter_2d_core_macros.svh"

module cmf2d_checker import cmf2d_pkg::*; #(
  parameter int DATA_BITS = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [PADDR_BITS-1:0] paddr,
  input logic [31:0]           pwdata,
  input logic [31:0]           prdata,
  input logic                  pready,
  input logic                  s_tready,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [DATA_BITS-1:0]  m_tdata,
  input logic                  m_tlast
);

  // Reset empties the pipeline, so the input side is open and nothing is offered.
  `CMF2D_ASSERT_RST(a_reset_empty, !m_tvalid && s_tready, "pipeline not empty after reset")

  // A held result keeps its payload until the transfer.
  `CMF2D_ASSERT_NEXT(a_out_hold,
    m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata) && $stable(m_tlast),
    "output changed while stalled")

  // With the sink ready the whole pipeline moves, so the input side must be open.
  `CMF2D_ASSERT_NOW(a_ready_flow, m_tready, s_tready, "input blocked while output side is ready")

  // A width write reads back on the following cycle.
  `CMF2D_ASSERT_NOW(a_width_readback,
    (psel && penable && pwrite && pready && paddr[REG_SEL_BIT] == REG_WIDTH) ##1
      (paddr[REG_SEL_BIT] == REG_WIDTH),
    prdata[WIDTH_REG_BITS-1:0] == $past(pwdata[WIDTH_REG_BITS-1:0]),
    "width register readback mismatch")

endmodule

bind cross_median_filter_2d_core cmf2d_checker #(
  .DATA_BITS (((SAMPLE_BITS + 7) / 8) * 8)
) u_cmf2d_checker (
  .clk      (clk),
  .rst      (rst),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .paddr    (paddr),
  .pwdata   (pwdata),
  .prdata   (prdata),
  .pready   (pready),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import cmf2d_pkg::*;

  localparam logic FUNC_PIXEL = ~FUNC_DRAIN;
  localparam int LINE_DEPTH = DEF_MAX_WIDTH;
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1000;

  typedef struct packed {
    logic signed [15:0] pixel;
    logic               frame_end;
  } filtered_pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [PADDR_BITS-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;  // pixel_in
  logic [0:0]  s_tuser = '0;  // func
  logic        m_tvalid;
  logic        m_tready = 1'b1;
  logic [15:0] m_tdata;       // pixel_out
  logic        m_tlast;

  cross_median_filter_2d_core dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  // Filter model state.
  logic [WIDTH_REG_BITS-1:0] width_setting;
  logic [HEIGHT_BITS-1:0]    height_setting;
  logic signed [15:0] upper_row [LINE_DEPTH];
  logic signed [15:0] middle_row [LINE_DEPTH];
  logic signed [15:0] cross_up, cross_left, cross_center, cross_right, cross_down;
  int unsigned col_pos, row_pos, emitted_pixels;

  filtered_pixel_t expected_pixels[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int sink_hold = 0;
  bit src_gaps = 1'b0;
  bit sink_stalls = 1'b0;

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
    emitted_pixels = 0;
    cross_up = '0;
    cross_left = '0;
    cross_center = '0;
    cross_right = '0;
    cross_down = '0;
  endfunction

  function automatic void reset_filter_model();
    width_setting = WIDTH_RESET;
    height_setting = HEIGHT_RESET;
    for (int k = 0; k < LINE_DEPTH; k++) begin
      upper_row[k] = '0;
      middle_row[k] = '0;
    end
    restart_frame();
  endfunction

  function automatic logic signed [15:0] cross_median(input logic signed [15:0] a, b, c, d, e);
    logic signed [15:0] vals [5];
    logic signed [15:0] t;
    vals[0] = a;
    vals[1] = b;
    vals[2] = c;
    vals[3] = d;
    vals[4] = e;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4 - i; j++)
        if (vals[j] > vals[j+1]) begin
          t = vals[j];
          vals[j] = vals[j+1];
          vals[j+1] = t;
        end
    return vals[2];
  endfunction

  // Advances the model by one accepted transfer; returns 1 when a pixel leaves.
  function automatic bit filter_step(input logic func, input logic signed [15:0] pix,
                                     output logic signed [15:0] result,
                                     output logic last_pixel);
    int unsigned w, h, col, pos, res_row, res_col;
    logic signed [15:0] x, mid, up;
    bit all_in, border, produced;
    w = (width_setting < MIN_DIM) ? MIN_DIM :
        (width_setting > LINE_DEPTH) ? LINE_DEPTH : width_setting;
    h = (height_setting < MIN_DIM) ? MIN_DIM : height_setting;
    all_in = row_pos >= h;
    result = '0;
    last_pixel = 1'b0;
    produced = 1'b0;
    // A drain before the frame is fully in is dropped.
    if (!all_in && func == FUNC_DRAIN)
      return 1'b0;
    x = all_in ? '0 : pix;
    col = (col_pos >= w) ? 0 : col_pos;
    pos = row_pos * w + col;
    mid = middle_row[col];
    up = upper_row[col];
    if (pos >= w + 1) begin
      cross_right = mid;
      if (col >= 1) begin
        res_row = row_pos - 1;
        res_col = col - 1;
      end else begin
        res_row = row_pos - 2;
        res_col = w - 1;
      end
      border = res_row == 0 || res_row == h - 1 || res_col == 0 || res_col == w - 1;
      result = border ? cross_center :
               cross_median(cross_up, cross_left, cross_center, cross_right, cross_down);
      last_pixel = emitted_pixels == w * h - 1;
      emitted_pixels++;
      produced = 1'b1;
      if (last_pixel) begin
        upper_row[col] = mid;
        middle_row[col] = x;
        restart_frame();
        return 1'b1;
      end
    end
    cross_up = up;
    cross_left = cross_center;
    cross_center = mid;
    cross_right = mid;
    cross_down = x;
    upper_row[col] = mid;
    middle_row[col] = x;
    col++;
    if (col >= w) begin
      col = 0;
      row_pos++;
    end
    col_pos = col;
    return produced;
  endfunction

  task automatic log_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch: %s expected %0d actual %0d", what, want, got);
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int idle_length();
    return ($urandom_range(0, 15) == 0) ? $urandom_range(12, 60) : $urandom_range(1, 3);
  endfunction

  function automatic logic signed [15:0] random_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2, 3: return 16'($urandom_range(0, 6)) - 16'd3;
      default: return 16'($urandom);
    endcase
  endfunction

  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else if (!sink_stalls) begin
      m_tready <= 1'b1;
    end else if (m_tready && $urandom_range(0, 2) == 0) begin
      m_tready <= 1'b0;
      sink_hold <= idle_length() - 1;
    end else begin
      m_tready <= 1'b1;
      sink_hold <= $urandom_range(0, 8);
    end
  end

  always @(posedge clk) begin : check_results
    filtered_pixel_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pixels.size() == 0) begin
        log_mismatch("unexpected output pixel", 0, $signed(m_tdata));
      end else begin
        want = expected_pixels.pop_front();
        if (m_tdata !== want.pixel)
          log_mismatch("pixel_out", want.pixel, $signed(m_tdata));
        if (m_tlast !== want.frame_end)
          log_mismatch("frame_end", want.frame_end, m_tlast);
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic send_item(logic func, logic signed [15:0] pix);
    int gap;
    logic signed [15:0] result;
    logic last_pixel;
    filtered_pixel_t entry;
    gap = (src_gaps && $urandom_range(0, 2) == 0) ? idle_length() : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= pix;
    do @(posedge clk); while (!s_tready);
    if (filter_step(func, pix, result, last_pixel)) begin
      entry.pixel = result;
      entry.frame_end = last_pixel;
      expected_pixels.insert(expected_pixels.size(), entry);
    end
  endtask

  task automatic wait_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
  endtask

  task automatic apb_access(logic write, logic reg_sel, logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= PADDR_BITS'(reg_sel) << REG_SEL_BIT;
    pwdata <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read_check(logic reg_sel);
    logic [31:0] rdata, want;
    apb_access(1'b0, reg_sel, '0, rdata);
    want = (reg_sel == REG_WIDTH) ? 32'(width_setting) : 32'(height_setting);
    if (rdata !== want)
      log_mismatch(reg_sel == REG_WIDTH ? "image_width readback" : "image_height readback",
                   want, rdata);
  endtask

  // Bits above the register width carry noise; the register keeps only its own bits.
  task automatic apb_write(logic reg_sel, int unsigned value);
    logic [31:0] rdata, wdata;
    if (reg_sel == REG_WIDTH)
      wdata = (32'($urandom) << WIDTH_REG_BITS) | value;
    else
      wdata = (32'($urandom) << HEIGHT_BITS) | value;
    apb_access(1'b1, reg_sel, wdata, rdata);
    if (reg_sel == REG_WIDTH)
      width_setting = wdata[WIDTH_REG_BITS-1:0];
    else
      height_setting = wdata[HEIGHT_BITS-1:0];
    restart_frame();
    apb_read_check(reg_sel);
  endtask

  task automatic set_geometry(int unsigned width_val, int unsigned height_val);
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    apb_write(REG_WIDTH, width_val);
    apb_write(REG_HEIGHT, height_val);
  endtask

  // Sends pixels in raster order with stray drains mixed in; a full frame is
  // followed by the w + 1 transfers that flush it, some of them surplus pixels.
  task automatic send_frame(int w, int h, int pixels, int pause_at);
    for (int k = 0; k < pixels; k++) begin
      if (k == pause_at)
        wait_results();
      if ($urandom_range(0, 15) == 0)
        send_item(FUNC_DRAIN, random_sample());
      send_item(FUNC_PIXEL, random_sample());
    end
    if (pixels == w * h)
      for (int k = 0; k <= w; k++)
        send_item(($urandom_range(0, 3) == 0) ? FUNC_PIXEL : FUNC_DRAIN, random_sample());
  endtask

  task automatic test_register_access();
    apb_read_check(REG_WIDTH);
    apb_read_check(REG_HEIGHT);
    apb_write(REG_WIDTH, 4095);
    apb_write(REG_HEIGHT, 65535);
    apb_write(REG_WIDTH, 0);
    apb_write(REG_HEIGHT, 0);
  endtask

  task automatic test_smallest_frame();
    logic [8:0][15:0] pattern;
    pattern = {16'd2, 16'h7FFF, 16'h8000, 16'd1, 16'd5, 16'hFFFF, 16'd0, 16'h8000, 16'h7FFF};
    src_gaps = 1'b0;
    sink_stalls = 1'b0;
    // Width 2 and height 1 are both raised to the minimum of 3.
    set_geometry(2, 1);
    send_item(FUNC_DRAIN, 16'h7FFF);
    for (int k = 0; k < 9; k++) begin
      send_item(FUNC_PIXEL, pattern[k]);
      if (k == 2)
        send_item(FUNC_DRAIN, 16'h8000);
    end
    send_item(FUNC_DRAIN, 16'h0000);
    send_item(FUNC_PIXEL, 16'h1234);
    send_item(FUNC_DRAIN, 16'hFFFF);
    send_item(FUNC_DRAIN, 16'h5555);
    send_item(FUNC_DRAIN, 16'hAAAA);
  endtask

  task automatic test_pause_for_results();
    src_gaps = 1'b1;
    sink_stalls = 1'b1;
    set_geometry(5, 4);
    send_frame(5, 4, 20, 11);
  endtask

  task automatic test_tall_frame_abort();
    src_gaps = 1'b0;
    sink_stalls = 1'b1;
    set_geometry(3, 65535);
    send_frame(3, 65535, 30, -1);
  endtask

  task automatic test_random_frames();
    int items, w, h, w_val, h_val, pixels, pause_at;
    items = 0;
    while (items < RANDOM_ITEMS) begin
      w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 48) : $urandom_range(3, 12);
      h = $urandom_range(3, 8);
      w_val = (w == 3 && $urandom_range(0, 1) == 1) ? $urandom_range(0, 2) : w;
      h_val = (h == 3 && $urandom_range(0, 1) == 1) ? $urandom_range(0, 2) : h;
      src_gaps = $urandom_range(0, 3) != 0;
      sink_stalls = $urandom_range(0, 3) != 0;
      set_geometry(w_val, h_val);
      repeat ($urandom_range(1, 3)) begin
        // Now and then a frame is cut short and restarted by the next register write.
        pixels = ($urandom_range(0, 9) == 0) ? $urandom_range(1, w * h - 1) : w * h;
        pause_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, pixels - 1) : -1;
        send_frame(w, h, pixels, pause_at);
        items += pixels + ((pixels == w * h) ? w + 1 : 0);
      end
    end
  endtask

  initial begin
    reset_filter_model();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_register_access();
    test_smallest_frame();
    test_pause_for_results();
    test_tall_frame_abort();
    test_random_frames();
    wait_results();
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/cmf2d_pkg.sv
sv/cmf2d_ram.sv
sv/cmf2d_median.sv
sv/cross_median_filter_2d_core.sv
sv/cmf2d_checker.sv
dv/testbench.sv
